/* hw/rtl/ttw_pkg.sv */
// ----------------------------------------------------------------------------
// ttw_pkg
// shared types and constants of the text terminal writer
// ----------------------------------------------------------------------------
package ttw_pkg;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int OLIN_W   = 11;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0B;

    // request kinds carried on s_tuser
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_FILL  = 4'b1000
    } seq_state_t;

    // first member sits in the highest bits, so cell_char ends up at bit 0
    typedef struct packed {
        logic                scrolled;
        logic [OLIN_W-1:0]   cursor_linear;
        logic [OROW_W-1:0]   cursor_row;
        logic [OCOL_W-1:0]   cursor_col;
        logic [ATTR_W-1:0]   cell_attribute;
        logic [CHAR_W-1:0]   cell_char;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t data;
    } result_push_t;

endpackage

/* hw/rtl/ttw_cell_ram.sv */
// ----------------------------------------------------------------------------
// ttw_cell_ram
// screen cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ttw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ttw_pkg::CELL_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [ttw_pkg::CELL_W-1:0] rdata
);

    logic [ttw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [ttw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ttw_seq.sv */
// ----------------------------------------------------------------------------
// ttw_seq
// request sequencer: cursor, scroll ring offset, row fill and clear sweep
// ----------------------------------------------------------------------------
module ttw_seq #(
    parameter int COLS  = 80,
    parameter int ROWS  = 25,
    parameter int CELLS = COLS * ROWS,
    parameter int AW    = $clog2(CELLS),
    parameter int CW    = $clog2(COLS),
    parameter int RW    = $clog2(ROWS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [7:0]                 char_code,
    input  logic [4:0]                 read_row,
    input  logic [6:0]                 read_col,
    input  logic [ttw_pkg::ATTR_W-1:0] attr,
    input  logic                       out_free,
    output ttw_pkg::result_push_t      res,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [ttw_pkg::CELL_W-1:0] ram_wdata,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_raddr,
    input  logic [ttw_pkg::CELL_W-1:0] ram_rdata
);

    ttw_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [AW-1:0]              base_reg, base_next;     // address of the top row
    logic [AW-1:0]              sweep_reg, sweep_next;   // fill / clear address
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [ttw_pkg::ATTR_W-1:0] fill_attr_reg, fill_attr_next;
    logic                       rd_ok_reg, rd_ok_next;

    logic                       accept;
    logic                       in_range;
    logic [RW-1:0]              map_row;
    logic [CW-1:0]              map_col;
    logic [AW:0]                map_sum;
    logic [AW-1:0]              map_addr;
    logic                       last_col;
    logic                       last_row;
    logic [AW:0]                base_sum;

    assign in_ready = (state_reg == ttw_pkg::ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLS);

    // logical row/col to ring address
    assign map_row  = (req_type == ttw_pkg::REQ_READ) ? RW'(read_row) : row_reg;
    assign map_col  = (req_type == ttw_pkg::REQ_READ) ? CW'(read_col) : col_reg;
    assign map_sum  = (AW+1)'(map_row) * (AW+1)'(COLS) + (AW+1)'(map_col)
                    + (AW+1)'(base_reg);
    assign map_addr = (map_sum >= (AW+1)'(CELLS)) ? AW'(map_sum - (AW+1)'(CELLS))
                                                  : AW'(map_sum);

    assign last_col = (col_reg == CW'(COLS - 1));
    assign last_row = (row_reg == RW'(ROWS - 1));
    assign base_sum = (AW+1)'(base_reg) + (AW+1)'(COLS);

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        fill_attr_next = fill_attr_reg;
        rd_ok_next     = rd_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = map_addr;
        ram_wdata      = {attr, char_code};
        ram_re         = 1'b0;
        ram_raddr      = map_addr;
        res            = '0;

        case (state_reg)
            ttw_pkg::ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = {fill_attr_reg, ttw_pkg::SPACE_CHAR};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    state_next = ttw_pkg::ST_IDLE;
                end
            end
            ttw_pkg::ST_IDLE:
            begin
                if (accept && (req_type == ttw_pkg::REQ_PUT))
                begin
                    ram_we   = 1'b1;
                    res.push = 1'b1;
                    if (!last_col)
                    begin
                        col_next = col_reg + CW'(1);
                    end
                    else
                    begin
                        col_next = '0;
                        if (!last_row)
                        begin
                            row_next = row_reg + RW'(1);
                        end
                        else
                        begin
                            // old top row becomes the new bottom row
                            res.data.scrolled = 1'b1;
                            sweep_next        = base_reg;
                            cnt_next          = '0;
                            fill_attr_next    = attr;
                            base_next         = (base_sum >= (AW+1)'(CELLS)) ? '0
                                                                             : AW'(base_sum);
                            state_next        = ttw_pkg::ST_FILL;
                        end
                    end
                    res.data.cursor_col    = ttw_pkg::OCOL_W'(col_next);
                    res.data.cursor_row    = ttw_pkg::OROW_W'(row_next);
                    res.data.cursor_linear = ttw_pkg::OLIN_W'(AW'(row_next) * AW'(COLS)
                                                              + AW'(col_next));
                end
                else if (accept)
                begin
                    ram_re     = in_range;
                    rd_ok_next = in_range;
                    state_next = ttw_pkg::ST_READ;
                end
            end
            ttw_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    res.push = 1'b1;
                    if (rd_ok_reg)
                    begin
                        res.data.cell_char      = ram_rdata[ttw_pkg::CHAR_W-1:0];
                        res.data.cell_attribute = ram_rdata[ttw_pkg::CELL_W-1:ttw_pkg::CHAR_W];
                    end
                    res.data.cursor_col    = ttw_pkg::OCOL_W'(col_reg);
                    res.data.cursor_row    = ttw_pkg::OROW_W'(row_reg);
                    res.data.cursor_linear = ttw_pkg::OLIN_W'(AW'(row_reg) * AW'(COLS)
                                                              + AW'(col_reg));
                    state_next             = ttw_pkg::ST_IDLE;
                end
            end
            ttw_pkg::ST_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = {fill_attr_reg, ttw_pkg::SPACE_CHAR};
                sweep_next = sweep_reg + AW'(1);
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(COLS - 1))
                begin
                    state_next = ttw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttw_pkg::ST_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            fill_attr_reg <= ttw_pkg::ATTR_RESET;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            fill_attr_reg <= fill_attr_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

endmodule

/* hw/rtl/text_terminal_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer_unit
// text-mode terminal engine over a COLS x ROWS cell store
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          word
//  s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: char, row, col
//  m_*       out  m_tvalid/m_tready  tdata: cell, cursor, linear, scrolled
//  cfg_*     in   cfg_valid/cfg_ready text attribute (always ready)
//
//  a put is written and answered from IDLE; a read goes on to READ (one registered ram read port)
//  a put that scrolls is followed by a bottom-row fill of COLS cells through
//  the single ram write port; scrolling itself only moves a ring offset
//  after reset a clearing pass over all ROWS*COLS cells (2000 at 80x25) fills the
//  store with spaces before the first word is taken
//  a result waiting on m_tready holds s_tready low; a word is taken only
//  while the output register is empty or draining
//
module text_terminal_writer_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cell_char, cell_attribute, cursor_col, cursor_row,
                                   // cursor_linear, scrolled
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_attribute
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [ttw_pkg::ATTR_W-1:0] attr_reg;
    logic                       out_valid_reg;
    ttw_pkg::result_t           out_data_reg;
    logic                       out_free;
    ttw_pkg::result_push_t      res;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ttw_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [ttw_pkg::CELL_W-1:0] ram_rdata;

    // attribute register; the user must write it only while the block is quiet, the block itself does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ttw_pkg::ATTR_RESET;
        end
        else if (cfg_valid)
        begin
            attr_reg <= cfg_data;
        end
    end

    // output register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            out_data_reg <= res.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    ttw_seq #(
        .COLS  (COLS),
        .ROWS  (ROWS),
        .CELLS (CELLS),
        .AW    (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (s_tuser),
        .char_code (s_tdata[7:0]),
        .read_row  (s_tdata[12:8]),
        .read_col  (s_tdata[19:13]),
        .attr      (attr_reg),
        .out_free  (out_free),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ttw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
